// ----- src/aliquot_sum_classifier_unit_defines.svh -----
// Assertion macros used by asc_seq.
`ifndef ALIQUOT_SUM_CLASSIFIER_UNIT_DEFINES_SVH
`define ALIQUOT_SUM_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ASC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asc: implication check failed");
`define ASC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asc: next-cycle check failed");
`else
`define ASC_ASSERT_IMP(lbl, ante, cons)
`define ASC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- src/asc_pkg.sv -----
`default_nettype none

package asc_pkg;

    localparam int NUM_WIDTH_DEF = 16;
    localparam int NUMBER_W      = 16;
    localparam int DSUM_W        = 19;
    localparam int CLASS_W       = 2;
    localparam int MASK_W        = 4;
    localparam int TDATA_OUT_W   = 40;

    localparam logic [DSUM_W-1:0] DSUM_MAX = '1;

    localparam int MASK_DEFICIENT_BIT = 0;
    localparam int MASK_PERFECT_BIT   = 1;
    localparam int MASK_ABUNDANT_BIT  = 2;
    localparam int MASK_PRIME_BIT     = 3;

    typedef enum logic [CLASS_W-1:0] {
        CLS_DEFICIENT = 2'd0,
        CLS_PERFECT   = 2'd1,
        CLS_ABUNDANT  = 2'd2,
        CLS_PRIME     = 2'd3
    } class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT,
        ST_CHECK,
        ST_CLASSIFY,
        ST_EMIT
    } seq_state_t;

endpackage

`default_nettype wire

// ----- src/asc_div.sv -----
`default_nettype none

module asc_div #(
    parameter int WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic      [WIDTH-1:0] quotient,
    output logic      [WIDTH-1:0] remainder,
    output logic                  done
);
    import asc_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// ----- src/asc_seq.sv -----
`default_nettype none
`include "aliquot_sum_classifier_unit_defines.svh"

module asc_seq #(
    parameter int NUM_WIDTH = asc_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [asc_pkg::NUMBER_W-1:0] in_number,
    input  wire logic [asc_pkg::MASK_W-1:0]   filter_mask,
    output logic                              div_start,
    output logic      [NUM_WIDTH-1:0]         div_a,
    output logic      [NUM_WIDTH-1:0]         div_b,
    input  wire logic [NUM_WIDTH-1:0]         div_q,
    input  wire logic [NUM_WIDTH-1:0]         div_r,
    input  wire logic                         div_done,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic      [asc_pkg::NUMBER_W-1:0] res_number,
    output logic      [asc_pkg::DSUM_W-1:0]   res_sum,
    output logic      [asc_pkg::CLASS_W-1:0]  res_class
);
    import asc_pkg::*;

    localparam int SUM_W = NUM_WIDTH + 3;
    localparam int CMP_W = (SUM_W > DSUM_W) ? SUM_W : DSUM_W;

    seq_state_t           state_reg, state_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] i_reg, i_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    class_t               cls_reg, cls_next;
    logic [NUM_WIDTH-1:0] n_in;
    logic [SUM_W-1:0]     n_ext;
    logic [NUM_WIDTH-1:0] add_i;
    logic [NUM_WIDTH-1:0] add_q;
    logic                 stop;
    logic                 match;
    logic                 accept;

    assign n_in   = NUM_WIDTH'(in_number);
    assign n_ext  = SUM_W'(n_reg);
    assign accept = in_valid && in_ready;
    assign stop   = i_reg > div_q;
    assign add_i  = (div_r == '0 && i_reg != n_reg) ? i_reg : '0;
    assign add_q  = (div_r == '0 && div_q != i_reg && div_q != n_reg) ? div_q : '0;

    always_comb
    begin
        match    = 1'b1;
        cls_next = cls_reg;
        priority if (filter_mask[MASK_DEFICIENT_BIT] && sum_reg < n_ext)
            cls_next = CLS_DEFICIENT;
        else if (filter_mask[MASK_PERFECT_BIT] && sum_reg == n_ext)
            cls_next = CLS_PERFECT;
        else if (filter_mask[MASK_ABUNDANT_BIT] && sum_reg > n_ext)
            cls_next = CLS_ABUNDANT;
        else if (filter_mask[MASK_PRIME_BIT] && sum_reg == SUM_W'(1))
            cls_next = CLS_PRIME;
        else
            match = 1'b0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (n_in == '0) ? ST_CLASSIFY : ST_DIV;
            end
            ST_DIV:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
                state_next = stop ? ST_CLASSIFY : ST_DIV;
            ST_CLASSIFY:
                state_next = match ? ST_EMIT : ST_IDLE;
            ST_EMIT:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:     in_ready  = 1'b1;
            ST_DIV:      div_start = 1'b1;
            ST_EMIT:     res_valid = 1'b1;
            ST_WAIT, ST_CHECK, ST_CLASSIFY: ;
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        n_next   = n_reg;
        i_next   = i_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            n_next   = n_in;
            i_next   = NUM_WIDTH'(1);
            sum_next = '0;
        end
        else if (state_reg == ST_CHECK && !stop)
        begin
            sum_next = sum_reg + SUM_W'(add_i) + SUM_W'(add_q);
            i_next   = i_reg + NUM_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        i_reg   <= i_next;
        sum_reg <= sum_next;
        if (state_reg == ST_CLASSIFY)
            cls_reg <= cls_next;
    end

    assign div_a      = n_reg;
    assign div_b      = i_reg;
    assign res_number = NUMBER_W'(n_reg);
    assign res_sum    = (CMP_W'(sum_reg) > CMP_W'(DSUM_MAX)) ? DSUM_MAX : DSUM_W'(sum_reg);
    assign res_class  = cls_reg;

    `ASC_ASSERT_IMP(a_class_enabled, res_valid, filter_mask[res_class])
    `ASC_ASSERT_IMP(a_perfect_sum, res_valid && res_class == CLS_PERFECT, sum_reg == n_ext)
    `ASC_ASSERT_NXT(a_stop_classify, state_reg == ST_CHECK && stop, state_reg == ST_CLASSIFY)
    `ASC_ASSERT_NXT(a_sum_grows, state_reg == ST_CHECK, sum_reg >= $past(sum_reg))

endmodule

`default_nettype wire

// ----- src/aliquot_sum_classifier_unit.sv -----
// Throughput: one number at a time; the next request is taken once the result has moved
//   into the output register, which waits while that register is still full. A zero
//   request skips the divider. The single restoring divider tests one candidate divisor
//   at a time, pairing i with n / i.
// Reset (rst_n, async, active low) clears the filter mask and all control state.
`default_nettype none

module aliquot_sum_classifier_unit #(
    parameter int NUM_WIDTH = asc_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [asc_pkg::NUMBER_W-1:0]    s_axis_tdata,  // [15:0] number_in
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [asc_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // [15:0] number_out,
                                                                // [34:16] divisor_sum
    output logic      [asc_pkg::CLASS_W-1:0]     m_axis_tuser,  // [1:0] matched_class
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [asc_pkg::MASK_W-1:0]      cfg_data       // [3:0] filter_mask
);
    import asc_pkg::*;

    logic [MASK_W-1:0]    mask_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [NUMBER_W-1:0]  out_number_reg;
    logic [DSUM_W-1:0]    out_sum_reg;
    logic [CLASS_W-1:0]   out_class_reg;

    logic                 div_start;
    logic                 div_done;
    logic [NUM_WIDTH-1:0] div_a, div_b, div_q, div_r;
    logic                 res_valid, res_ready;
    logic [NUMBER_W-1:0]  res_number;
    logic [DSUM_W-1:0]    res_sum;
    logic [CLASS_W-1:0]   res_class;

    asc_div #(
        .WIDTH (NUM_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    asc_seq #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_number   (s_axis_tdata),
        .filter_mask (mask_reg),
        .div_start   (div_start),
        .div_a       (div_a),
        .div_b       (div_b),
        .div_q       (div_q),
        .div_r       (div_r),
        .div_done    (div_done),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_number  (res_number),
        .res_sum     (res_sum),
        .res_class   (res_class)
    );

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mask_reg <= cfg_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_number_reg <= res_number;
            out_sum_reg    <= res_sum;
            out_class_reg  <= res_class;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_OUT_W'({out_sum_reg, out_number_reg});
    assign m_axis_tuser  = out_class_reg;

endmodule

`default_nettype wire

// ----- sim/tb_aliquot_sum_classifier_unit.sv -----
`timescale 1ns / 1ps

module tb_aliquot_sum_classifier_unit;
    import asc_pkg::*;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [DSUM_W-1:0]   dsum;
        class_t              cls;
    } classified_t;

    localparam logic [MASK_W-1:0] MASK_NONE      = '0;
    localparam logic [MASK_W-1:0] MASK_ALL       = '1;
    localparam logic [MASK_W-1:0] ONLY_DEFICIENT = MASK_W'(1 << MASK_DEFICIENT_BIT);
    localparam logic [MASK_W-1:0] ONLY_PERFECT   = MASK_W'(1 << MASK_PERFECT_BIT);
    localparam logic [MASK_W-1:0] ONLY_ABUNDANT  = MASK_W'(1 << MASK_ABUNDANT_BIT);
    localparam logic [MASK_W-1:0] ONLY_PRIME     = MASK_W'(1 << MASK_PRIME_BIT);

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [NUMBER_W-1:0]    s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [CLASS_W-1:0]     m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [MASK_W-1:0]      cfg_data = '0;

    classified_t         pending_results[$];
    logic [MASK_W-1:0]   active_mask = '0;
    logic [NUMBER_W-1:0] last_number = '0;
    bit                  steady_flow = 1'b0;
    int unsigned         errors = 0;
    int unsigned         numbers_sent = 0;
    int unsigned         results_checked = 0;
    int unsigned         mask_writes = 0;
    int unsigned         class_hits[4] = '{0, 0, 0, 0};

    aliquot_sum_classifier_unit #(
        .NUM_WIDTH(NUM_WIDTH_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("** aliquot_sum_classifier_unit: FAILED **");
        $finish;
    end

    function automatic int unsigned proper_divisor_sum(input logic [NUMBER_W-1:0] n);
        int unsigned acc;
        int unsigned half;
        acc = 0;
        half = n / 2;
        for (int unsigned i = 1; i <= half; i++)
        begin
            if (n % i == 0)
                acc += i;
        end
        return acc;
    endfunction

    function automatic int unsigned settle_cycles(input logic [NUMBER_W-1:0] n);
        int unsigned root;
        root = 0;
        while ((root + 1) * (root + 1) <= n)
            root++;
        return 2 * (root + 2) * (NUMBER_W + 3) + 64;
    endfunction

    task automatic predict_number(input logic [NUMBER_W-1:0] n);
        int unsigned total;
        classified_t item;
        bit          hit;
        total = proper_divisor_sum(n);
        hit = 1'b1;
        item.cls = CLS_DEFICIENT;
        if (active_mask[MASK_DEFICIENT_BIT] && total < n)
            item.cls = CLS_DEFICIENT;
        else if (active_mask[MASK_PERFECT_BIT] && total == n)
            item.cls = CLS_PERFECT;
        else if (active_mask[MASK_ABUNDANT_BIT] && total > n)
            item.cls = CLS_ABUNDANT;
        else if (active_mask[MASK_PRIME_BIT] && total == 1)
            item.cls = CLS_PRIME;
        else
            hit = 1'b0;
        if (hit)
        begin
            item.number = n;
            item.dsum = (total > DSUM_MAX) ? DSUM_MAX : total[DSUM_W-1:0];
            pending_results.push_back(item);
        end
    endtask

    task automatic send_number(input logic [NUMBER_W-1:0] n);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= n;
        do @(posedge clk); while (!s_axis_tready);
        predict_number(n);
        numbers_sent++;
        last_number = n;
    endtask

    // drop the request, then hold until every expected result is in
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_mask(input logic [MASK_W-1:0] m);
        wait_drained();
        repeat (settle_cycles(last_number)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_mask = m;
        mask_writes++;
    endtask

    // result sink with random backpressure
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        classified_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result number=%0d sum=%0d class=%0d", $realtime,
                         m_axis_tdata[15:0], m_axis_tdata[34:16], m_axis_tuser);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== want.number)
                begin
                    $display("%0t: number_out expected %0d actual %0d", $realtime,
                             want.number, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[34:16] !== want.dsum)
                begin
                    $display("%0t: divisor_sum of %0d expected %0d actual %0d", $realtime,
                             want.number, want.dsum, m_axis_tdata[34:16]);
                    errors++;
                end
                if (m_axis_tuser !== want.cls)
                begin
                    $display("%0t: matched_class of %0d expected %0d actual %0d", $realtime,
                             want.number, want.cls, m_axis_tuser);
                    errors++;
                end
                results_checked++;
                class_hits[want.cls]++;
            end
        end
    end

    task automatic test_mask_after_reset();
        send_number(16'd6);
        send_number(16'd1);
        send_number(16'd65535);
    endtask

    task automatic test_each_class();
        set_mask(MASK_ALL);
        send_number(16'd1);
        send_number(16'd2);
        send_number(16'd12);
        send_number(16'd28);
        send_number(16'd0);
        send_number(16'd65535);
        set_mask(ONLY_PRIME);
        send_number(16'd2);
        send_number(16'd65521);
        send_number(16'd1);
        send_number(16'd4);
        set_mask(ONLY_ABUNDANT);
        send_number(16'd945);
        send_number(16'd65520);
        send_number(16'd6);
        set_mask(ONLY_PERFECT);
        send_number(16'd496);
        send_number(16'd8128);
        send_number(16'd0);
        send_number(16'd7);
        set_mask(ONLY_DEFICIENT);
        send_number(16'd0);
        send_number(16'd3);
        send_number(16'd65534);
    endtask

    function automatic logic [NUMBER_W-1:0] draw_number();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return NUMBER_W'($urandom_range(0, 65535));
        if (pick == 2)
        begin
            case ($urandom_range(0, 3))
                0: return 16'd6;
                1: return 16'd28;
                2: return 16'd496;
                default: return 16'd8128;
            endcase
        end
        return NUMBER_W'($urandom_range(1, 2000));
    endfunction

    task automatic test_random_numbers();
        logic [MASK_W-1:0] m;
        for (int phase = 0; phase < 5; phase++)
        begin
            m = (phase == 0) ? MASK_ALL : MASK_W'($urandom_range(1, 15));
            set_mask(m);
            steady_flow = (phase == 2);
            for (int k = 0; k < 20; k++)
            begin
                if (phase == 3 && k == 10)
                    wait_drained();
                send_number(draw_number());
            end
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_mask_after_reset();
        test_each_class();
        test_random_numbers();

        wait_drained();
        repeat (settle_cycles(last_number)) @(posedge clk);

        $display("Classified %0d numbers across %0d filter settings, %0d results checked.",
                 numbers_sent, mask_writes, results_checked);
        $display("Hits: deficient %0d, perfect %0d, abundant %0d, prime %0d.",
                 class_hits[0], class_hits[1], class_hits[2], class_hits[3]);
        if (errors == 0)
            $display("** aliquot_sum_classifier_unit: PASSED **");
        else
            $display("** aliquot_sum_classifier_unit: FAILED **");
        $finish;
    end

endmodule

// ----- aliquot_sum_classifier_unit.f -----
+incdir+src
src/asc_pkg.sv
src/asc_div.sv
src/asc_seq.sv
src/aliquot_sum_classifier_unit.sv
sim/tb_aliquot_sum_classifier_unit.sv
